// ----- rtl/flr_pkg.sv -----
// Package for the focal law delay calculator: widths, constants, shared types.
// No dependencies.
`default_nettype none
package flr_pkg;

  localparam int MAX_ELEMENTS = 16;

  localparam int CNT_W   = 5;
  localparam int PITCH_W = 7;
  localparam int FD_W    = 11;
  localparam int IDX_W   = 4;
  localparam int OFF_W   = 12;
  localparam int AX_W    = 11;
  localparam int Y_W     = 12;
  localparam int S_W     = 25;
  localparam int T_W     = 18;
  localparam int RD_W    = 21;
  localparam int CIDX_W  = 2;
  localparam int CDAT_W  = 11;

  // square root unit: 60-bit radicand, 30-bit root
  localparam int ROOT_W  = 30;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 2;

  localparam logic [CIDX_W-1:0] CFG_COUNT = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_PITCH = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_DEPTH = 2'd2;

  localparam logic [CNT_W-1:0]   RST_COUNT = 5'd16;
  localparam logic [PITCH_W-1:0] RST_PITCH = 7'd10;
  localparam logic [FD_W-1:0]    RST_DEPTH = 11'd400;

  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(MAX_ELEMENTS);

  // reciprocals: ceil(2^29/37), ceil(2^20/5), ceil(2^40/625)
  localparam logic [23:0] RECIP37  = 24'd14510025;
  localparam logic [17:0] RECIP5   = 18'd209716;
  localparam logic [30:0] RECIP625 = 31'd1759218605;

  localparam logic [9:0]  NS_MUL   = 10'd625;
  localparam logic [12:0] LEN_MUL  = 13'd4736;
  localparam logic [17:0] OFF_MUL  = 18'd160000;

  typedef struct packed {
    logic [CNT_W-1:0]   count;
    logic [PITCH_W-1:0] pitch;
    logic [FD_W-1:0]    depth;
  } cfg_t;

  typedef struct packed {
    logic                    err;
    logic signed [OFF_W-1:0] off;
    logic [AX_W-1:0]         ax;
    logic [T_W-1:0]          t;
    logic [T_W-1:0]          q;
    logic                    clamped;
  } side_t;

endpackage
`default_nettype wire

// ----- rtl/focal_law_delay_calc_core.sv -----
// Focal law delay calculator, top level.
// Uses flr_pkg, flr_cfg, flr_front, flr_isqrt, flr_mid, flr_back.
//
//   channel | signals                                  | direction
//   in      | in_valid/in_ready, in_element_index      | word in
//   out     | out_valid/out_ready, six result fields   | word out
//   cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data | register write
//
// One word per cycle while no result waits on out_ready; stages: 2 front,
// 30 + 30 square root, 7 middle, 2 back. Synchronous active-low reset clears all
// valid bits and loads the register defaults. The whole pipe holds while a
// result waits on out_ready; no word is dropped or repeated.
`default_nettype none
module focal_law_delay_calc_core import flr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [IDX_W-1:0]  in_element_index,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [OFF_W-1:0] out_lateral_offset,
  output logic [T_W-1:0]         out_flight_time_ns,
  output logic [T_W-1:0]         out_quantized_time_ns,
  output logic [RD_W-1:0]        out_reached_depth,
  output logic                   out_depth_clamped,
  output logic                   out_index_error,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CDAT_W-1:0] cfg_data
);

  cfg_t              cfg;
  logic              en;
  logic              f_v, s1_v, m_v, s2_v;
  logic [RAD_W-1:0]  f_rad, m_rad;
  logic [ROOT_W-1:0] s1_root, s2_root;
  side_t             f_side, s1_side, m_side, s2_side;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  flr_cfg u_cfg (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .cfg
  );

  flr_front u_front (
    .clk, .rst_n, .en, .in_v(in_valid), .idx(in_element_index), .cfg,
    .out_v(f_v), .rad(f_rad), .side(f_side)
  );

  flr_isqrt u_path_sqrt (
    .clk, .rst_n, .en, .in_v(f_v), .rad(f_rad), .in_side(f_side),
    .out_v(s1_v), .root(s1_root), .out_side(s1_side)
  );

  flr_mid u_mid (
    .clk, .rst_n, .en, .in_v(s1_v), .hq(s1_root), .in_side(s1_side),
    .out_v(m_v), .rad(m_rad), .out_side(m_side)
  );

  flr_isqrt u_depth_sqrt (
    .clk, .rst_n, .en, .in_v(m_v), .rad(m_rad), .in_side(m_side),
    .out_v(s2_v), .root(s2_root), .out_side(s2_side)
  );

  flr_back u_back (
    .clk, .rst_n, .en, .in_v(s2_v), .root(s2_root), .in_side(s2_side),
    .out_valid, .out_lateral_offset, .out_flight_time_ns, .out_quantized_time_ns,
    .out_reached_depth, .out_depth_clamped, .out_index_error
  );

endmodule
`default_nettype wire

// ----- rtl/flr_cfg.sv -----
// Configuration registers: element count, pitch, focal depth.
// Uses flr_pkg.
`default_nettype none
module flr_cfg import flr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CDAT_W-1:0] cfg_data,
  output cfg_t                   cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.count <= RST_COUNT;
      cfg_r.pitch <= RST_PITCH;
      cfg_r.depth <= RST_DEPTH;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_COUNT: cfg_r.count <= cfg_data[CNT_W-1:0];
        CFG_PITCH: cfg_r.pitch <= cfg_data[PITCH_W-1:0];
        CFG_DEPTH: cfg_r.depth <= cfg_data[FD_W-1:0];
        default:   cfg_r       <= cfg_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/flr_front.sv -----
// Front stages: lateral offset, index check, squared path length.
// Uses flr_pkg.
`default_nettype none
module flr_front import flr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_v,
  input  wire logic [IDX_W-1:0] idx,
  input  wire cfg_t             cfg,
  output logic                  out_v,
  output logic [RAD_W-1:0]      rad,
  output side_t                 side
);

  logic [CNT_W-1:0]        n_use;
  logic                    err;
  logic signed [6:0]       coef;
  logic signed [14:0]      x_full;
  logic                    va_r, vb_r;
  logic                    erra_r;
  logic signed [OFF_W-1:0] xa_r;
  logic [Y_W-1:0]          ya_r;
  logic [AX_W-1:0]         ax;
  logic [S_W-1:0]          s_nxt, s_r;
  side_t                   side_r;

  assign n_use  = (cfg.count > CNT_CAP) ? CNT_CAP : cfg.count;
  assign err    = {1'b0, idx} >= n_use;
  assign coef   = $signed({2'b00, n_use}) - 7'sd1 - $signed({2'b00, idx, 1'b0});
  // for a valid index |x| <= 15 * 127, fits the offset field
  assign x_full = coef * $signed({1'b0, cfg.pitch});

  assign ax    = xa_r[OFF_W-1] ? AX_W'(-xa_r) : AX_W'(xa_r);
  assign s_nxt = S_W'(ax * ax) + S_W'(ya_r * ya_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= in_v;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      erra_r         <= err;
      xa_r           <= x_full[OFF_W-1:0];
      ya_r           <= {cfg.depth, 1'b0};
      s_r            <= s_nxt;
      side_r.err     <= erra_r;
      side_r.off     <= xa_r;
      side_r.ax      <= ax;
      side_r.t       <= '0;
      side_r.q       <= '0;
      side_r.clamped <= 1'b0;
    end
  end

  assign out_v = vb_r;
  assign rad   = {{(RAD_W-S_W-16){1'b0}}, s_r, 16'h0000};
  assign side  = side_r;

endmodule
`default_nettype wire

// ----- rtl/flr_isqrt.sv -----
// Pipelined integer square root, one root bit per stage, side data carried along.
// Uses flr_pkg.
`default_nettype none
module flr_isqrt import flr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_v,
  input  wire logic [RAD_W-1:0] rad,
  input  wire side_t            in_side,
  output logic                  out_v,
  output logic [ROOT_W-1:0]     root,
  output side_t                 out_side
);

  logic              v_r    [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [RAD_W-1:0]  rad_r  [ROOT_W];
  side_t             side_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_st
    logic              v_i;
    logic [REM_W-1:0]  rem_i;
    logic [ROOT_W-1:0] root_i;
    logic [RAD_W-1:0]  rad_i;
    side_t             side_i;
    logic [REM_W+1:0]  rem_sh, trial, rem_sub;
    logic              ge;

    if (k == 0) begin : g_head
      assign v_i    = in_v;
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = rad;
      assign side_i = in_side;
    end else begin : g_body
      assign v_i    = v_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign rad_i  = rad_r[k-1];
      assign side_i = side_r[k-1];
    end

    assign rem_sh  = {rem_i, rad_i[RAD_W-1 -: 2]};
    assign trial   = {root_i, 2'b01};
    assign ge      = rem_sh >= trial;
    assign rem_sub = rem_sh - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
        root_r[k] <= {root_i[ROOT_W-2:0], ge};
        rad_r[k]  <= {rad_i[RAD_W-3:0], 2'b00};
        side_r[k] <= side_i;
      end
    end
  end

  assign out_v    = v_r[ROOT_W-1];
  assign root     = root_r[ROOT_W-1];
  assign out_side = side_r[ROOT_W-1];

endmodule
`default_nettype wire

// ----- rtl/flr_mid.sv -----
// Middle stages: path length to ns, 10 ns quantization, depth radicand.
// Uses flr_pkg.
`default_nettype none
module flr_mid import flr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_v,
  input  wire logic [ROOT_W-1:0] hq,
  input  wire side_t             in_side,
  output logic                   out_v,
  output logic [RAD_W-1:0]       rad,
  output side_t                  out_side
);

  localparam int NST = 7;

  logic        v_r [NST];
  side_t       s_r [NST];

  logic [30:0] p1_r;
  logic [46:0] p2_r;
  logic [34:0] p3_r;
  logic [T_W-1:0] t;
  logic [14:0] qd;
  logic [T_W-1:0] q_nxt;
  logic [T_W-1:0] q_r;
  logic [30:0] a_r, b_r;
  logic [30:0] dif_r;
  logic [31:0] sum_r;
  logic        clamp_nxt;
  logic [RAD_W-1:0] d_r;
  side_t       s2_nxt, s3_nxt, s5_nxt;

  assign t         = p2_r[46:29];
  assign qd        = p3_r[34:20];
  assign q_nxt     = T_W'({qd, 3'b000}) + T_W'({qd, 1'b0});
  assign clamp_nxt = a_r < b_r;

  always_comb begin
    s2_nxt         = s_r[1];
    s2_nxt.t       = t;
    s3_nxt         = s_r[2];
    s3_nxt.q       = q_nxt;
    s5_nxt         = s_r[4];
    s5_nxt.clamped = clamp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
      for (int i = 1; i < NST; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r[0] <= in_side;
      s_r[1] <= s_r[0];
      s_r[2] <= s2_nxt;
      s_r[3] <= s3_nxt;
      s_r[4] <= s_r[3];
      s_r[5] <= s5_nxt;
      s_r[6] <= s_r[5];

      p1_r  <= 31'(hq[20:0] * NS_MUL);
      p2_r  <= p1_r[29:7] * RECIP37;
      p3_r  <= t[T_W-1:1] * RECIP5;
      q_r   <= q_nxt;
      a_r   <= 31'(q_r * LEN_MUL);
      b_r   <= 31'(s_r[3].ax * OFF_MUL);
      dif_r <= a_r - b_r;
      sum_r <= {1'b0, a_r} + {1'b0, b_r};
      d_r   <= s_r[5].clamped ? '0 : RAD_W'(dif_r * sum_r);
    end
  end

  assign out_v    = v_r[NST-1];
  assign rad      = d_r;
  assign out_side = s_r[NST-1];

endmodule
`default_nettype wire

// ----- rtl/flr_back.sv -----
// Back stages: depth scale by 1/625 and the output register.
// Uses flr_pkg.
`default_nettype none
module flr_back import flr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_v,
  input  wire logic [ROOT_W-1:0] root,
  input  wire side_t             in_side,
  output logic                   out_valid,
  output logic signed [OFF_W-1:0] out_lateral_offset,
  output logic [T_W-1:0]         out_flight_time_ns,
  output logic [T_W-1:0]         out_quantized_time_ns,
  output logic [RD_W-1:0]        out_reached_depth,
  output logic                   out_depth_clamped,
  output logic                   out_index_error
);

  logic        v1_r, vo_r;
  logic [60:0] prod_r;
  side_t       s1_r;
  logic [RD_W-1:0] depth;
  logic        ok;

  assign depth = prod_r[60:40];
  assign ok    = !s1_r.err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      vo_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r                <= root * RECIP625;
      s1_r                  <= in_side;
      out_lateral_offset    <= ok ? s1_r.off : '0;
      out_flight_time_ns    <= ok ? s1_r.t : '0;
      out_quantized_time_ns <= ok ? s1_r.q : '0;
      out_reached_depth     <= (ok && !s1_r.clamped) ? depth : '0;
      out_depth_clamped     <= ok && s1_r.clamped;
      out_index_error       <= s1_r.err;
    end
  end

  assign out_valid = vo_r;

endmodule
`default_nettype wire

// ----- rtl/flr_chk.sv -----
// Port-level checks for the focal law delay calculator, bound to the top level.
// Uses flr_pkg.
`default_nettype none
module flr_chk import flr_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic signed [OFF_W-1:0] out_lateral_offset,
  input wire logic [T_W-1:0]    out_flight_time_ns,
  input wire logic [T_W-1:0]    out_quantized_time_ns,
  input wire logic [RD_W-1:0]   out_reached_depth,
  input wire logic              out_depth_clamped,
  input wire logic              out_index_error
);

  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_index_error |-> out_lateral_offset == '0 &&
      out_flight_time_ns == '0 && out_quantized_time_ns == '0 &&
      out_reached_depth == '0 && !out_depth_clamped)
    else $error("index error word has nonzero fields");

  a_quant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_index_error |-> out_quantized_time_ns <= out_flight_time_ns &&
      (out_flight_time_ns - out_quantized_time_ns) < T_W'(10))
    else $error("quantized time off");

  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_depth_clamped |-> out_reached_depth == '0)
    else $error("clamped depth nonzero");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_flight_time_ns))
    else $error("stalled word changed");

endmodule

bind focal_law_delay_calc_core flr_chk u_chk (.*);
`default_nettype wire
